FILE: hdl/per_user_quota_table_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the per-user quota table
// Shared property forms used by the checker.
// ---------------------------------------------------------------------------
`ifndef PER_USER_QUOTA_TABLE_UNIT_DEFINES_SVH
`define PER_USER_QUOTA_TABLE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PUQT_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("quota table property failed");

// The consequent must hold in the cycle after the antecedent.
`define PUQT_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("quota table property failed");

`endif

FILE: hdl/puqt_pkg.sv
// ---------------------------------------------------------------------------
// Quota table package
// Sizes, codes and record types shared by the quota table modules.
// ---------------------------------------------------------------------------
package puqt_pkg;

  // Number of table entries and the index width that follows from it.
  localparam int ENTRIES = 32;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef logic [IDX_W-1:0] idx_t;

  // Item actions.
  typedef enum logic [1:0] {
    ACT_SET     = 2'd0,
    ACT_CHARGE  = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_CHECK   = 2'd3
  } act_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_FULL        = 3'd1,
    ST_BLK_REFUSED = 3'd2,
    ST_INO_REFUSED = 3'd3,
    ST_NOT_FOUND   = 3'd4,
    ST_BLK_OVER    = 3'd5,
    ST_INO_OVER    = 3'd6
  } status_t;

  // Sequencer states.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Counters and limits of one entry, held together in the record memory.
  typedef struct packed {
    logic [63:0] blocks_used;
    logic [63:0] inodes_used;
    logic [63:0] blocks_cap;
    logic [63:0] inodes_cap;
  } rec_t;

  // Outcome of a user search.
  typedef struct packed {
    logic hit;
    logic full;
    idx_t idx;
  } lookup_t;

  // Allocation of a new entry to a user.
  typedef struct packed {
    logic        we;
    idx_t        idx;
    logic [31:0] user;
  } alloc_t;

endpackage

FILE: hdl/puqt_lookup.sv
// ---------------------------------------------------------------------------
// Quota table user lookup
// Holds the valid bits and user keys, and finds the entry of a user or the
// lowest free entry.
// ---------------------------------------------------------------------------
module puqt_lookup (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [31:0]      key,
  input  puqt_pkg::alloc_t alloc,
  output puqt_pkg::lookup_t res
);
  import puqt_pkg::*;

  logic [ENTRIES-1:0] valid_r;
  logic [31:0]        user_r [ENTRIES];

  logic hit;
  logic has_free;
  idx_t hit_idx;
  idx_t free_idx;

  // Valid bits clear at reset; an allocation marks its entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (alloc.we) begin
      valid_r[alloc.idx] <= 1'b1;
    end
  end

  // User keys need no reset: they are only compared where valid.
  always_ff @(posedge clk) begin
    if (alloc.we) begin
      user_r[alloc.idx] <= alloc.user;
    end
  end

  // Parallel compare; scanning downwards leaves the lowest index standing.
  always_comb begin
    hit      = 1'b0;
    has_free = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && (user_r[i] == key)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        has_free = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  assign res.hit  = hit;
  assign res.full = !hit && !has_free;
  assign res.idx  = hit ? hit_idx : free_idx;

endmodule

FILE: hdl/per_user_quota_table_unit.sv
// ---------------------------------------------------------------------------
// Per-user quota table
// Block and inode usage counters per user with hard limits; a limit of zero
// means unlimited.
// ---------------------------------------------------------------------------
//
//  Channel   Handshake             Ports
//  input     start && !busy        in_action, in_user_id, in_block_count,
//                                  in_inode_count, in_block_limit, in_inode_limit
//  result    out_valid strobe      out_status
//
// An item is handled in two steps: the user search and record read on the accept
// edge, then a read-modify-write on the record memory in the execute state. busy is
// high in that execute state; the result strobe follows in the next cycle, while the
// next item may already be accepted. The single-port record memory sets the
// rate. Reset clears the valid bits at once; no clearing pass is needed.
// The receiver cannot stall, so results never wait.
//
module per_user_quota_table_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_user_id,
  input  logic [63:0] in_block_count,
  input  logic [63:0] in_inode_count,
  input  logic [63:0] in_block_limit,
  input  logic [63:0] in_inode_limit,
  output logic        out_valid,
  output logic [2:0]  out_status
);
  import puqt_pkg::*;

  state_t  state_r, state_nxt;
  lookup_t lk;
  alloc_t  alloc;
  logic    accept;

  // Item held for the execute cycle.
  act_t        act_r;
  logic [31:0] uid_r;
  logic [63:0] bcnt_r, icnt_r, blim_r, ilim_r;
  lookup_t     lk_r;

  rec_t rec_mem [ENTRIES];
  rec_t rd_r;

  logic        out_valid_r, out_valid_nxt;
  status_t     status_r, status_nxt;

  // Execute-stage signals.
  logic        alloc_ok;
  logic        present;
  rec_t        base;
  rec_t        wr_rec;
  logic [64:0] bsum, isum;
  logic        bexc, iexc;

  assign accept = start && (state_r == S_IDLE);

  puqt_lookup u_lookup (
    .clk   (clk),
    .rst_n (rst_n),
    .key   (in_user_id),
    .alloc (alloc),
    .res   (lk)
  );

  // State and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Item capture and record read on the accept edge.
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r  <= act_t'(in_action);
      uid_r  <= in_user_id;
      bcnt_r <= in_block_count;
      icnt_r <= in_inode_count;
      blim_r <= in_block_limit;
      ilim_r <= in_inode_limit;
      lk_r   <= lk;
      rd_r   <= rec_mem[lk.idx];
    end
  end

  // Record write back in the execute cycle.
  always_ff @(posedge clk) begin
    if ((state_r == S_EXEC) && present) begin
      rec_mem[lk_r.idx] <= wr_rec;
    end
  end

  // Status payload register.
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
  end

  // Execute: allocate where needed, test the limits, update the counters or limits and set the status.
  always_comb begin
    alloc_ok = !lk_r.hit && !lk_r.full &&
               ((act_r == ACT_SET) || (act_r == ACT_CHARGE));
    present  = lk_r.hit || alloc_ok;

    // A new entry starts with zero usage; a charge gives it no limits.
    if (alloc_ok) begin
      base.blocks_used = '0;
      base.inodes_used = '0;
      base.blocks_cap  = (act_r == ACT_SET) ? blim_r : '0;
      base.inodes_cap  = (act_r == ACT_SET) ? ilim_r : '0;
    end else begin
      base = rd_r;
    end

    bsum = {1'b0, base.blocks_used} + {1'b0, bcnt_r};
    isum = {1'b0, base.inodes_used} + {1'b0, icnt_r};
    bexc = (base.blocks_cap != '0) && (bsum > {1'b0, base.blocks_cap});
    iexc = (base.inodes_cap != '0) && (isum > {1'b0, base.inodes_cap});

    wr_rec     = base;
    status_nxt = ST_OK;
    case (act_r)
      ACT_SET: begin
        if (!present) begin
          status_nxt = ST_FULL;
        end else begin
          wr_rec.blocks_cap = blim_r;
          wr_rec.inodes_cap = ilim_r;
        end
      end
      ACT_CHARGE: begin
        if (!present) begin
          status_nxt = ST_FULL;
        end else if (bexc) begin
          status_nxt = ST_BLK_REFUSED;
        end else if (iexc) begin
          status_nxt = ST_INO_REFUSED;
        end else begin
          // Only unlimited counters can carry out; they saturate.
          wr_rec.blocks_used = bsum[64] ? '1 : bsum[63:0];
          wr_rec.inodes_used = isum[64] ? '1 : isum[63:0];
        end
      end
      ACT_RELEASE: begin
        if (!present) begin
          status_nxt = ST_NOT_FOUND;
        end else begin
          wr_rec.blocks_used = (base.blocks_used >= bcnt_r) ?
                               base.blocks_used - bcnt_r : '0;
          wr_rec.inodes_used = (base.inodes_used >= icnt_r) ?
                               base.inodes_used - icnt_r : '0;
        end
      end
      ACT_CHECK: begin
        if (present) begin
          if ((base.blocks_cap != '0) && (base.blocks_used > base.blocks_cap)) begin
            status_nxt = ST_BLK_OVER;
          end else if ((base.inodes_cap != '0) &&
                       (base.inodes_used > base.inodes_cap)) begin
            status_nxt = ST_INO_OVER;
          end
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase

    alloc.we   = (state_r == S_EXEC) && alloc_ok;
    alloc.idx  = lk_r.idx;
    alloc.user = uid_r;
  end

  // Sequencer: each accepted item passes through the execute state.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy       = (state_r == S_EXEC);
  assign out_valid  = out_valid_r;
  assign out_status = status_r;

endmodule

FILE: hdl/puqt_checker.sv
// ---------------------------------------------------------------------------
// Quota table port checker
// Watches the ports of the quota table for item and result timing.
// ---------------------------------------------------------------------------
`include "per_user_quota_table_unit_defines.svh"

module puqt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [2:0]  out_status
);
  import puqt_pkg::*;

  // An accepted item raises busy for its execute state alone.
  `PUQT_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy)
  `PUQT_ASSERT_NEXT(a_busy_one_cycle, busy, !busy)

  // Every accepted item yields its result once it has passed the execute state and the result register.
  `PUQT_ASSERT_NOW(a_result_follows, start && !busy, ##2 out_valid)

  // Results never come back to back, and carry a defined status code.
  `PUQT_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid)
  `PUQT_ASSERT_NOW(a_status_code, out_valid, out_status <= ST_INO_OVER)

endmodule

bind per_user_quota_table_unit puqt_checker u_puqt_checker (.*);

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Per-user quota table testbench
// Sends set, charge, release and check requests through the start/busy
// handshake and compares every status strobe with a local model of the
// table. Directed requests cover limits, refusals, saturation and a full
// table; random requests then work over a fixed set of users and some unknown ones.
// ---------------------------------------------------------------------------
module tb_top;
  import puqt_pkg::*;

  localparam int        IDLE_LIMIT   = 500;
  localparam int        MAX_REPORTS  = 10;
  localparam int        RANDOM_ITEMS = 500;
  localparam int        POOL_SIZE    = ENTRIES;
  localparam bit [63:0] ALL_ONES     = '1;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_action;
  logic [31:0] in_user_id;
  logic [63:0] in_block_count;
  logic [63:0] in_inode_count;
  logic [63:0] in_block_limit;
  logic [63:0] in_inode_limit;
  logic        out_valid;
  logic [2:0]  out_status;

  // Local copy of the quota table.
  bit          quota_valid [ENTRIES];
  bit [31:0]   quota_user  [ENTRIES];
  bit [63:0]   blk_used    [ENTRIES];
  bit [63:0]   ino_used    [ENTRIES];
  bit [63:0]   blk_cap     [ENTRIES];
  bit [63:0]   ino_cap     [ENTRIES];

  status_t     expected_status_q[$];
  bit [31:0]   user_pool[POOL_SIZE];
  int          fail_count;
  int          idle_cycles;
  bit          idle_on;

  per_user_quota_table_unit uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_action     (in_action),
    .in_user_id    (in_user_id),
    .in_block_count(in_block_count),
    .in_inode_count(in_inode_count),
    .in_block_limit(in_block_limit),
    .in_inode_limit(in_inode_limit),
    .out_valid     (out_valid),
    .out_status    (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Slot holding a user, or -1 when the user has no entry.
  function automatic int find_slot(bit [31:0] uid);
    for (int i = 0; i < ENTRIES; i++)
      if (quota_valid[i] && quota_user[i] == uid)
        return i;
    return -1;
  endfunction

  // Takes the lowest free slot with cleared counters; -1 when none is left.
  function automatic int claim_slot(bit [31:0] uid, bit [63:0] bcap, bit [63:0] icap);
    for (int i = 0; i < ENTRIES; i++) begin
      if (!quota_valid[i]) begin
        quota_valid[i] = 1'b1;
        quota_user[i]  = uid;
        blk_used[i]    = '0;
        ino_used[i]    = '0;
        blk_cap[i]     = bcap;
        ino_cap[i]     = icap;
        return i;
      end
    end
    return -1;
  endfunction

  // A charge breaks a nonzero limit when the sum, carry included, is above it.
  function automatic bit over_cap(bit [63:0] used, bit [63:0] amt, bit [63:0] cap);
    bit [64:0] total;
    total = {1'b0, used} + {1'b0, amt};
    return (cap != 0) && (total > {1'b0, cap});
  endfunction

  function automatic bit [63:0] add_clamped(bit [63:0] a, bit [63:0] b);
    bit [64:0] total;
    total = {1'b0, a} + {1'b0, b};
    return total[64] ? ALL_ONES : total[63:0];
  endfunction

  // Applies one request to the local table and returns the status it gives.
  function automatic status_t apply_request(act_t act, bit [31:0] uid,
                                            bit [63:0] bcnt, bit [63:0] icnt,
                                            bit [63:0] blim, bit [63:0] ilim);
    int      slot;
    status_t st;
    st   = ST_OK;
    slot = find_slot(uid);
    case (act)
      ACT_SET: begin
        if (slot >= 0) begin
          blk_cap[slot] = blim;
          ino_cap[slot] = ilim;
        end else if (claim_slot(uid, blim, ilim) < 0) begin
          st = ST_FULL;
        end
      end
      ACT_CHARGE: begin
        if (slot < 0)
          slot = claim_slot(uid, '0, '0);
        if (slot < 0) begin
          st = ST_FULL;
        end else if (over_cap(blk_used[slot], bcnt, blk_cap[slot])) begin
          st = ST_BLK_REFUSED;
        end else if (over_cap(ino_used[slot], icnt, ino_cap[slot])) begin
          st = ST_INO_REFUSED;
        end else begin
          blk_used[slot] = add_clamped(blk_used[slot], bcnt);
          ino_used[slot] = add_clamped(ino_used[slot], icnt);
        end
      end
      ACT_RELEASE: begin
        if (slot < 0) begin
          st = ST_NOT_FOUND;
        end else begin
          blk_used[slot] = (blk_used[slot] >= bcnt) ? blk_used[slot] - bcnt : '0;
          ino_used[slot] = (ino_used[slot] >= icnt) ? ino_used[slot] - icnt : '0;
        end
      end
      default: begin
        if (slot >= 0) begin
          if (blk_cap[slot] != 0 && blk_used[slot] > blk_cap[slot])
            st = ST_BLK_OVER;
          else if (ino_cap[slot] != 0 && ino_used[slot] > ino_cap[slot])
            st = ST_INO_OVER;
        end
      end
    endcase
    return st;
  endfunction

  function automatic bit in_pool(bit [31:0] uid, int count);
    for (int i = 0; i < count; i++)
      if (user_pool[i] == uid)
        return 1'b1;
    return 1'b0;
  endfunction

  // A user id that is not among the regular users.
  function automatic bit [31:0] fresh_user();
    bit [31:0] uid;
    do
      uid = $urandom;
    while (in_pool(uid, POOL_SIZE));
    return uid;
  endfunction

  // Amounts lean towards small values so that limits are reached often.
  function automatic bit [63:0] pick_amount();
    bit [63:0] wide;
    wide = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:          return '0;
      1, 2, 3, 4: return 64'($urandom_range(0, 40));
      5:          return ALL_ONES - 64'($urandom_range(0, 40));
      6:          return ALL_ONES;
      7:          return 64'(1) << $urandom_range(0, 63);
      8:          return 64'($urandom_range(0, 2000));
      default:    return wide;
    endcase
  endfunction

  function automatic bit [63:0] pick_limit();
    bit [63:0] wide;
    wide = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1, 2: return '0;
      3, 4, 5: return 64'($urandom_range(1, 120));
      6:       return 64'($urandom_range(1, 3000));
      7:       return ALL_ONES;
      8:       return ALL_ONES - 64'($urandom_range(1, 40));
      default: return wide;
    endcase
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("mismatch: %s", msg);
  endfunction

  // Sends one item, records its expected status once it is taken, then
  // leaves a random gap when idling is enabled.
  task automatic send_item(input act_t act, input bit [31:0] uid,
                           input bit [63:0] bcnt, input bit [63:0] icnt,
                           input bit [63:0] blim, input bit [63:0] ilim);
    int gap;
    in_action      = act;
    in_user_id     = uid;
    in_block_count = bcnt;
    in_inode_count = icnt;
    in_block_limit = blim;
    in_inode_limit = ilim;
    start          = 1'b1;
    do
      @(posedge clk);
    while (busy !== 1'b0);
    expected_status_q.push_back(apply_request(act, uid, bcnt, icnt, blim, ilim));
    @(negedge clk);
    gap = 0;
    if (idle_on) begin
      case ($urandom_range(0, 99)) inside
        [0:49]:  gap = 0;
        [50:84]: gap = $urandom_range(1, 3);
        [85:96]: gap = $urandom_range(4, 10);
        default: gap = $urandom_range(20, 40);
      endcase
    end
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Limits, refusals, over-limit checks and releases that floor at zero.
  task automatic test_limits_and_refusals();
    bit [31:0] uid;
    uid = user_pool[0];
    send_item(ACT_CHECK,   uid, 64'd0,    64'd0,    64'd0,   64'd0);
    send_item(ACT_RELEASE, uid, 64'd1,    64'd1,    64'd0,   64'd0);
    send_item(ACT_SET,     uid, 64'd0,    64'd0,    64'd100, 64'd10);
    send_item(ACT_CHARGE,  uid, 64'd100,  64'd10,   64'd0,   64'd0);
    send_item(ACT_CHARGE,  uid, 64'd1,    64'd0,    64'd0,   64'd0);
    send_item(ACT_CHARGE,  uid, 64'd0,    64'd1,    64'd0,   64'd0);
    send_item(ACT_SET,     uid, 64'd0,    64'd0,    64'd50,  64'd5);
    // Both limits would break; the block test must win.
    send_item(ACT_CHARGE,  uid, 64'd100,  64'd100,  64'd0,   64'd0);
    send_item(ACT_CHECK,   uid, 64'd0,    64'd0,    64'd0,   64'd0);
    send_item(ACT_RELEASE, uid, 64'd60,   64'd0,    64'd0,   64'd0);
    send_item(ACT_CHECK,   uid, 64'd0,    64'd0,    64'd0,   64'd0);
    send_item(ACT_RELEASE, uid, ALL_ONES, ALL_ONES, 64'd0,   64'd0);
    send_item(ACT_CHECK,   uid, 64'd0,    64'd0,    64'd0,   64'd0);
  endtask

  // Unlimited counters saturate; a full-scale limit refuses on carry.
  task automatic test_unlimited_saturation();
    bit [31:0] uid;
    uid = user_pool[1];
    send_item(ACT_CHARGE,  uid, ALL_ONES, ALL_ONES, 64'd0,    64'd0);
    send_item(ACT_CHARGE,  uid, 64'd5,    64'd5,    64'd0,    64'd0);
    send_item(ACT_RELEASE, uid, 64'd1,    64'd0,    64'd0,    64'd0);
    send_item(ACT_SET,     uid, 64'd0,    64'd0,    ALL_ONES, ALL_ONES);
    send_item(ACT_CHARGE,  uid, 64'd1,    64'd0,    64'd0,    64'd0);
    send_item(ACT_CHARGE,  uid, 64'd1,    64'd0,    64'd0,    64'd0);
    send_item(ACT_CHARGE,  uid, 64'd0,    64'd1,    64'd0,    64'd0);
    send_item(ACT_SET,     uid, 64'd0,    64'd0,    64'd0,    64'd0);
    send_item(ACT_CHARGE,  uid, 64'd1,    64'd1,    64'd0,    64'd0);
  endtask

  // Gives every regular user an entry, then tries an unknown user.
  task automatic test_table_full();
    bit [31:0] stranger;
    for (int i = 0; i < POOL_SIZE; i++)
      if (find_slot(user_pool[i]) < 0)
        send_item(($urandom_range(0, 1) != 0) ? ACT_SET : ACT_CHARGE, user_pool[i],
                  pick_amount(), pick_amount(), pick_limit(), pick_limit());
    stranger = fresh_user();
    send_item(ACT_SET,     stranger, 64'd1, 64'd1, 64'd10, 64'd10);
    send_item(ACT_CHARGE,  stranger, 64'd1, 64'd1, 64'd0,  64'd0);
    send_item(ACT_RELEASE, stranger, 64'd1, 64'd1, 64'd0,  64'd0);
    send_item(ACT_CHECK,   stranger, 64'd0, 64'd0, 64'd0,  64'd0);
  endtask

  // Mostly regular users with random amounts and limits, some unknown users.
  task automatic test_random_requests();
    act_t      act;
    bit [31:0] uid;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0)
        idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0)
        uid = fresh_user();
      else
        uid = user_pool[$urandom_range(0, POOL_SIZE - 1)];
      case ($urandom_range(0, 9))
        0, 1:       act = ACT_SET;
        2, 3, 4, 5: act = ACT_CHARGE;
        6, 7:       act = ACT_RELEASE;
        default:    act = ACT_CHECK;
      endcase
      send_item(act, uid, pick_amount(), pick_amount(), pick_limit(), pick_limit());
    end
  endtask

  // Every status strobe is matched against the oldest expectation.
  always @(posedge clk) begin
    status_t want;
    if (rst_n && out_valid) begin
      if (expected_status_q.size() == 0) begin
        note_failure($sformatf("status %0d arrived with nothing expected", out_status));
      end else begin
        want = expected_status_q.pop_front();
        if (out_status !== want)
          note_failure($sformatf("status expected %0d (%s), got %0d",
                                 want, want.name(), out_status));
      end
    end
  end

  // Ends the run when nothing has moved on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[per_user_quota_table_unit] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    bit [31:0] cand;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_action      = ACT_SET;
    in_user_id     = '0;
    in_block_count = '0;
    in_inode_count = '0;
    in_block_limit = '0;
    in_inode_limit = '0;
    fail_count     = 0;
    idle_cycles    = 0;
    idle_on        = 1'b1;

    // Regular users: the two extreme ids and distinct random ones.
    user_pool[0] = '0;
    user_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) begin
      do
        cand = $urandom;
      while (in_pool(cand, i));
      user_pool[i] = cand;
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_limits_and_refusals();
    test_unlimited_saturation();
    test_table_full();
    test_random_requests();

    // Drain the outstanding results, then watch for stray strobes before the verdict.
    start = 1'b0;
    while (expected_status_q.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("[per_user_quota_table_unit] OK");
    else
      $display("[per_user_quota_table_unit] ERROR");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/puqt_pkg.sv
hdl/puqt_lookup.sv
hdl/per_user_quota_table_unit.sv
hdl/puqt_checker.sv
test/tb_top.sv
